// ----- rtl/core/pcnd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcnd_pkg
// Shared types and constants of the prefix-code nibble decoder: field widths,
// op codes, register map and the layout of one code table entry.
// ----------------------------------------------------------------------------
package pcnd_pkg;

    // payload field widths
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 5;
    localparam int LEN_W     = 5;
    localparam int CODE_W    = 16;
    localparam int SYM_W     = 4;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 17;

    // op codes of an input beat
    localparam logic [OP_W-1:0] OP_DATA    = 2'd0;
    localparam logic [OP_W-1:0] OP_ENTRY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_OUTPUT_LENGTH = 1'b0;
    localparam logic [CODE_W-1:0] OUTPUT_LENGTH_RST = 16'hFFFF;

    // one code table word
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  sym;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              finished;
        logic              no_match;
    } t_result;

endpackage

// ----- rtl/core/pcnd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcnd_if
// Valid/ready channels of the prefix-code nibble decoder: the input beat
// (data byte, table entry write or restart) and the result beat.
// ----------------------------------------------------------------------------
interface pcnd_in_if
    import pcnd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  entry_index;
    logic [LEN_W-1:0]  entry_length;
    logic [CODE_W-1:0] entry_code;
    logic [SYM_W-1:0]  entry_symbol;

    modport source (
        output valid, op, data_byte, entry_index, entry_length, entry_code,
               entry_symbol,
        input  ready
    );
    modport sink (
        input  valid, op, data_byte, entry_index, entry_length, entry_code,
               entry_symbol,
        output ready
    );
endinterface

interface pcnd_out_if
    import pcnd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              finished;
    logic              no_match;

    modport source (
        output valid, out_byte, last, finished, no_match,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last, finished, no_match,
        output ready
    );
endinterface

// ----- rtl/core/prefix_code_nibble_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_nibble_decoder_unit
// Prefix-code decoder with 4-bit symbols packed two per output byte. The
// code table is a synchronous memory scanned one entry a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  i_in carries one beat per op: a compressed byte, a table entry write or a
//  stream restart. o_out carries result beats (decoded byte, last, finished,
//  no_match); last marks the final result beat caused by one input beat.
//  The APB port holds output_length at byte address 0.
// Sequence:
//  Table writes, restarts and ignored beats are handled in S_IDLE. A data
//  byte is accepted in S_IDLE; S_SCAN then finds each decoded symbol by
//  reading table entries in order from index 0 up to the matching one (all
//  entries on a miss), and S_FLUSH releases the final result, if any. The
//  single table read port limits the scan to one entry per cycle. A result
//  passes through r_hold and the output register r_o before reaching o_out.
// Reset / stall:
//  Synchronous reset clears the bit buffer, counters and stop flag and sets
//  output_length to 65535; the table is undefined until written.
//  A result waits in an output register; when o_out stalls, scanning halts
//  at the next result while a second one is already held.
// ----------------------------------------------------------------------------
module prefix_code_nibble_decoder_unit
    import pcnd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcnd_in_if.sink               i_in,
    pcnd_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [1:0]        r_state,  n_state;
    logic [IW-1:0]     r_idx,    n_idx;
    logic [CODE_W-1:0] r_buf,    n_buf;
    logic [LEN_W-1:0]  r_held,   n_held;
    logic              r_pend_v, n_pend_v;
    logic [SYM_W-1:0]  r_pend,   n_pend;
    logic [CODE_W-1:0] r_bw,     n_bw;
    logic              r_stop,   n_stop;
    logic [CODE_W-1:0] r_olen;
    logic              r_hold_v, n_hold_v;
    t_result           r_hold,   n_hold;
    logic              r_ov,     n_ov;
    t_result           r_o,      n_o;
    logic              r_olast,  n_olast;

    // table memory
    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rdata;
    logic [IW-1:0]     rd_addr;
    t_entry            wr_entry;
    logic              wr_en;

    // handshake
    logic in_acc;
    logic slot_free;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[APB_ADDR_W-1:2] == REG_OUTPUT_LENGTH);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_OUTPUT_LENGTH) ?
                    {{(APB_DATA_W-CODE_W){1'b0}}, r_olen} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olen <= OUTPUT_LENGTH_RST;
        end else if (cfg_wr) begin
            r_olen <= pwdata[CODE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    assign in_acc = i_in.valid && i_in.ready;
    assign wr_en  = in_acc && (i_in.op == OP_ENTRY) &&
                    (32'(i_in.entry_index) < 32'(TABLE_ENTRIES));
    assign wr_entry = '{len: i_in.entry_length, code: i_in.entry_code,
                        sym: i_in.entry_symbol};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[IW'(i_in.entry_index)] <= wr_entry;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // compare the top of the bit buffer with the entry just read
    // ------------------------------------------------------------------
    logic             len_ok;
    logic [LEN_W-1:0] sh_full;
    logic [3:0]       sh;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] want;
    logic             hit;

    assign len_ok  = (r_rdata.len != '0) && (r_rdata.len <= LEN_W'(CODE_W));
    assign sh_full = LEN_W'(CODE_W) - r_rdata.len;
    assign sh      = sh_full[3:0];
    assign mask    = {CODE_W{1'b1}} << sh;
    assign want    = r_rdata.code << sh;
    assign hit     = len_ok && ((r_buf & mask) == want);

    // decode step results
    logic [CODE_W-1:0] bw_inc;
    logic              made;
    logic [CODE_W-1:0] bw_new;
    logic              done_cnt;
    logic [LEN_W-1:0]  held_new;
    logic              miss;
    logic              produce;
    t_result           step_res;

    assign bw_inc   = r_bw + 16'd1;
    assign made     = r_pend_v;
    assign bw_new   = made ? bw_inc : r_bw;
    assign done_cnt = (bw_new >= r_olen);
    assign held_new = (r_rdata.len >= r_held) ? '0 : (r_held - r_rdata.len);
    assign miss     = !hit && (r_idx == IDX_LAST);
    assign produce  = miss || (hit && (made || done_cnt));

    always_comb begin
        if (miss) begin
            step_res = '{out_byte: '0, finished: 1'b0, no_match: 1'b1};
        end else if (made) begin
            step_res = '{out_byte: {r_pend, r_rdata.sym}, finished: done_cnt,
                         no_match: 1'b0};
        end else begin
            step_res = '{out_byte: '0, finished: 1'b1, no_match: 1'b0};
        end
    end

    assign slot_free   = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic [3:0]        app_sh;
    logic [CODE_W-1:0] app_bits;

    assign app_sh   = 4'd8 - r_held[3:0];
    assign app_bits = {{(CODE_W-BYTE_W){1'b0}}, i_in.data_byte} << app_sh;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_buf    = r_buf;
        n_held   = r_held;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_bw     = r_bw;
        n_stop   = r_stop;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_ov     = r_ov && !o_out.ready;
        n_o      = r_o;
        n_olast  = r_olast;
        rd_addr  = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.op)
                        OP_RESTART: begin
                            n_buf    = '0;
                            n_held   = '0;
                            n_pend_v = 1'b0;
                            n_bw     = '0;
                            n_stop   = 1'b0;
                        end
                        OP_DATA: begin
                            if (!r_stop) begin
                                n_buf   = r_buf | app_bits;
                                n_held  = r_held + LEN_W'(BYTE_W);
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (produce && r_hold_v && !slot_free) begin
                    // earlier result still blocked: re-read this entry
                    rd_addr = r_idx;
                end else if (!hit && !miss) begin
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end else begin
                    if (produce) begin
                        if (r_hold_v) begin
                            n_ov    = 1'b1;
                            n_o     = r_hold;
                            n_olast = 1'b0;
                        end
                        n_hold_v = 1'b1;
                        n_hold   = step_res;
                    end
                    if (miss) begin
                        n_stop  = 1'b1;
                        n_state = S_FLUSH;
                    end else begin
                        n_buf    = r_buf << r_rdata.len;
                        n_held   = held_new;
                        n_bw     = bw_new;
                        n_pend_v = !r_pend_v;
                        n_pend   = r_rdata.sym;
                        n_idx    = '0;
                        if (done_cnt) begin
                            n_stop  = 1'b1;
                            n_state = S_FLUSH;
                        end else if (held_new <= LEN_W'(BYTE_W)) begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_ov     = 1'b1;
                    n_o      = r_hold;
                    n_olast  = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_buf    <= '0;
            r_held   <= '0;
            r_pend_v <= 1'b0;
            r_bw     <= '0;
            r_stop   <= 1'b0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_buf    <= n_buf;
            r_held   <= n_held;
            r_pend_v <= n_pend_v;
            r_bw     <= n_bw;
            r_stop   <= n_stop;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pend  <= n_pend;
        r_hold  <= n_hold;
        r_o     <= n_o;
        r_olast <= n_olast;
    end

    // result channel
    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_o.out_byte;
    assign o_out.last     = r_olast;
    assign o_out.finished = r_o.finished;
    assign o_out.no_match = r_o.no_match;

`ifndef SYNTHESIS
    // no result is left held once the block is ready for a new beat
    a_hold_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held result left over in idle");

    // a stopped stream never scans
    a_scan_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_stop)
        else $error("scan while stopped");

    // bit count never exceeds the buffer
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= LEN_W'(CODE_W))
        else $error("bits held out of range");

    // a miss or a finish always closes the beat
    a_stop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o.no_match || r_o.finished)) |-> r_olast)
        else $error("terminal result not marked last");

    // scan index stays inside the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_idx) < 32'(TABLE_ENTRIES)))
        else $error("scan index past table");
`endif

endmodule

// ----- sim/pcnd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcnd_checker
// Watches the input channel, the result channel and the APB port of the
// prefix-code nibble decoder. Every accepted input beat runs through a local
// decoder model that queues the result beats it should cause. Every accepted
// result beat is compared field by field with the oldest queued beat.
// ----------------------------------------------------------------------------
module pcnd_checker
    import pcnd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcnd_in_if                    i_in_mon,
    pcnd_out_if                   i_out_mon,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              finished;
        logic              no_match;
    } t_dec_beat;

    // model copy of the code table
    logic [LEN_W-1:0]  code_len_q [TABLE_ENTRIES];
    logic [CODE_W-1:0] code_val_q [TABLE_ENTRIES];
    logic [SYM_W-1:0]  code_sym_q [TABLE_ENTRIES];

    // model copy of the stream state and the register
    logic [15:0]      bitbuf;
    int               held_bits;
    logic             nib_valid;
    logic [SYM_W-1:0] nib_val;
    logic [15:0]      byte_count;
    logic             halted;
    logic [15:0]      out_len;

    t_dec_beat expected_beats[$];
    int        fails;

    // first table entry whose code matches the top of the window, -1 if none
    function automatic int find_code(input logic [15:0] window);
        int          hit;
        int          l;
        logic [15:0] mask;
        logic [15:0] want;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            l = int'(code_len_q[i]);
            if (hit < 0 && l >= 1 && l <= 16) begin
                mask = 16'hFFFF << (16 - l);
                want = code_val_q[i] << (16 - l);
                if ((window & mask) == want) hit = i;
            end
        end
        return hit;
    endfunction

    // apply one input beat to the model and queue the result beats it causes
    task automatic decode_beat(input logic [OP_W-1:0]   op,
                               input logic [BYTE_W-1:0] data,
                               input logic [IDX_W-1:0]  idx,
                               input logic [LEN_W-1:0]  len,
                               input logic [CODE_W-1:0] code,
                               input logic [SYM_W-1:0]  sym);
        t_dec_beat         beats[$];
        t_dec_beat         b;
        int                hit;
        int                l;
        bit                first;
        bit                made;
        logic [BYTE_W-1:0] pair;
        case (op)
            OP_ENTRY: begin
                if (idx < TABLE_ENTRIES) begin
                    code_len_q[idx] = len;
                    code_val_q[idx] = code;
                    code_sym_q[idx] = sym;
                end
            end
            OP_RESTART: begin
                bitbuf     = '0;
                held_bits  = 0;
                nib_valid  = 1'b0;
                nib_val    = '0;
                byte_count = '0;
                halted     = 1'b0;
            end
            OP_DATA: begin
                if (!halted) begin
                    // new byte goes just below the bits still held (at most 8)
                    bitbuf    = bitbuf | (16'(data) << (8 - held_bits));
                    held_bits = held_bits + 8;
                    first     = 1'b1;
                    while (first || held_bits > 8) begin
                        first = 1'b0;
                        hit   = find_code(bitbuf);
                        if (hit < 0) begin
                            b          = '0;
                            b.no_match = 1'b1;
                            beats.push_back(b);
                            halted = 1'b1;
                            break;
                        end
                        l    = int'(code_len_q[hit]);
                        made = 1'b0;
                        pair = '0;
                        if (nib_valid) begin
                            pair      = {nib_val, code_sym_q[hit]};
                            nib_valid = 1'b0;
                            made      = 1'b1;
                        end else begin
                            nib_valid = 1'b1;
                            nib_val   = code_sym_q[hit];
                        end
                        // a code longer than the held bits eats the zero padding
                        bitbuf    = bitbuf << l;
                        held_bits = (l >= held_bits) ? 0 : held_bits - l;
                        if (made) begin
                            byte_count = byte_count + 16'd1;
                            b          = '0;
                            b.out_byte = pair;
                            b.finished = (byte_count >= out_len);
                            beats.push_back(b);
                        end
                        if (byte_count >= out_len) begin
                            // count reached without a fresh byte: empty finish beat
                            if (!made) begin
                                b          = '0;
                                b.finished = 1'b1;
                                beats.push_back(b);
                            end
                            halted = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: begin
                // unused op, nothing happens
            end
        endcase
        if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
        foreach (beats[k]) expected_beats.push_back(beats[k]);
    endtask

    task automatic report_fail(input string msg);
        fails++;
        if (fails <= 10) $display("%s", msg);
    endtask

    // predict on input beats, compare on result beats
    always @(posedge i_clk) begin
        t_dec_beat exp_b;
        t_dec_beat got_b;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                code_len_q[i] = '0;
                code_val_q[i] = '0;
                code_sym_q[i] = '0;
            end
            bitbuf     = '0;
            held_bits  = 0;
            nib_valid  = 1'b0;
            nib_val    = '0;
            byte_count = '0;
            halted     = 1'b0;
            out_len    = OUTPUT_LENGTH_RST;
            fails      = 0;
            expected_beats.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[APB_ADDR_W-1:2] == REG_OUTPUT_LENGTH) begin
                out_len = i_pwdata[15:0];
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_beat(i_in_mon.op, i_in_mon.data_byte, i_in_mon.entry_index,
                            i_in_mon.entry_length, i_in_mon.entry_code,
                            i_in_mon.entry_symbol);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got_b.out_byte = i_out_mon.out_byte;
                got_b.last     = i_out_mon.last;
                got_b.finished = i_out_mon.finished;
                got_b.no_match = i_out_mon.no_match;
                if (expected_beats.size() == 0) begin
                    report_fail($sformatf(
                        "unexpected result beat: byte %02h last %0b fin %0b nm %0b",
                        got_b.out_byte, got_b.last, got_b.finished, got_b.no_match));
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (got_b != exp_b) begin
                        report_fail({
                            $sformatf("result mismatch: expected byte %02h last %0b",
                                      exp_b.out_byte, exp_b.last),
                            $sformatf(" fin %0b nm %0b,", exp_b.finished,
                                      exp_b.no_match),
                            $sformatf(" got byte %02h last %0b fin %0b nm %0b",
                                      got_b.out_byte, got_b.last, got_b.finished,
                                      got_b.no_match)});
                    end
                end
            end
        end
        o_pending    = expected_beats.size();
        o_fail_count = fails;
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the prefix-code nibble decoder. A directed part
// loads a fixed 4-bit code and walks the corner cases (long codes, misses,
// stop and restart, finishing with no byte). Random phases then load random
// prefix-code tables, some with holes, and stream random bytes under several
// output lengths and idle patterns. pcnd_checker does all the comparing.
// ----------------------------------------------------------------------------
module testbench
    import pcnd_pkg::*;
;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int items_sent     = 0;

    pcnd_in_if  in_ch ();
    pcnd_out_if out_ch ();

    always #6 i_clk = ~i_clk;

    prefix_code_nibble_decoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pcnd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one input beat after a random gap, return at its accepting edge
    task automatic send_beat(input logic [OP_W-1:0]   op,
                             input logic [BYTE_W-1:0] data,
                             input logic [IDX_W-1:0]  idx,
                             input logic [LEN_W-1:0]  len,
                             input logic [CODE_W-1:0] code,
                             input logic [SYM_W-1:0]  sym);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.data_byte    <= data;
        in_ch.entry_index  <= idx;
        in_ch.entry_length <= len;
        in_ch.entry_code   <= code;
        in_ch.entry_symbol <= sym;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op != OP_UNUSED && !(op == OP_ENTRY && idx >= TABLE_ENTRIES_DEF))
            items_sent++;
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] data);
        send_beat(OP_DATA, data, IDX_W'($urandom), LEN_W'($urandom), CODE_W'($urandom),
                  SYM_W'($urandom));
    endtask

    task automatic send_entry(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] len,
                              input logic [CODE_W-1:0] code, input logic [SYM_W-1:0] sym);
        send_beat(OP_ENTRY, BYTE_W'($urandom), idx, len, code, sym);
    endtask

    task automatic send_restart();
        send_beat(OP_RESTART, BYTE_W'($urandom), IDX_W'($urandom), LEN_W'($urandom),
                  CODE_W'($urandom), SYM_W'($urandom));
    endtask

    // stop offering and wait for every queued result
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // drained, plus time for a byte that yields no result to finish
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_OUTPUT_LENGTH);
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random complete prefix code by leaf splitting, sometimes with a hole
    task automatic load_table();
        int          lens [TABLE_ENTRIES_DEF];
        int          codes [TABLE_ENTRIES_DEF];
        int          n;
        int          j;
        int          t;
        int          maxl;
        bit          chain;
        logic [15:0] code_w;
        chain   = ($urandom_range(0, 2) == 0);
        maxl    = (chain || $urandom_range(0, 3) == 0) ? 16 : $urandom_range(5, 9);
        lens[0] = 0;
        codes[0] = 0;
        n = 1;
        while (n < TABLE_ENTRIES_DEF) begin
            j = chain ? n - 1 : $urandom_range(0, n - 1);
            if (lens[j] < maxl) begin
                lens[n]  = lens[j] + 1;
                codes[n] = codes[j] * 2 + 1;
                lens[j]  = lens[j] + 1;
                codes[j] = codes[j] * 2;
                n++;
            end
        end
        // scatter the leaves over the table
        for (int i = TABLE_ENTRIES_DEF - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = lens[i];  lens[i]  = lens[j];  lens[j]  = t;
            t = codes[i]; codes[i] = codes[j]; codes[j] = t;
        end
        // a hole: this entry never matches, so its codes miss
        if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
            lens[j] = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        end
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
            // bits above the code length are don't-care
            code_w = 16'(codes[i]) | (16'($urandom) << lens[i]);
            send_entry(IDX_W'(i), LEN_W'(lens[i]), code_w, SYM_W'($urandom));
        end
    endtask

    // one random phase: register setting, idle pattern, then byte streams
    task automatic run_phase(input int send_pct, input int recv_pct, input logic [15:0] len,
                             input int max_bytes, input int quota, input bit with_hold,
                             input bit with_drain);
        int start;
        int nbytes;
        bit drained;
        settle();
        write_length(len);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (with_hold) hold_reqs <= hold_reqs + 1;
        start   = items_sent;
        drained = 1'b0;
        while (items_sent - start < quota) begin
            if ($urandom_range(0, 9) == 0) load_table();
            if ($urandom_range(0, 3) != 0) send_restart();
            nbytes = $urandom_range(1, max_bytes);
            repeat (nbytes) begin
                if (items_sent - start >= quota) break;
                case ($urandom_range(0, 39))
                    0: send_beat(OP_UNUSED, BYTE_W'($urandom), IDX_W'($urandom),
                                 LEN_W'($urandom), CODE_W'($urandom), SYM_W'($urandom));
                    1: send_entry(IDX_W'($urandom_range(TABLE_ENTRIES_DEF, 31)),
                                  LEN_W'($urandom), CODE_W'($urandom), SYM_W'($urandom));
                    2: send_entry(IDX_W'($urandom_range(0, TABLE_ENTRIES_DEF - 1)),
                                  LEN_W'($urandom), CODE_W'($urandom), SYM_W'($urandom));
                    default: send_data(BYTE_W'($urandom));
                endcase
            end
            if (with_drain && !drained && items_sent - start >= quota / 2) begin
                drain();
                drained = 1'b1;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int seen;
        seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seen != hold_reqs) begin
                seen = hold_reqs;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: too long with no beat on any port
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.op           <= OP_DATA;
        in_ch.data_byte    <= '0;
        in_ch.entry_index  <= '0;
        in_ch.entry_length <= '0;
        in_ch.entry_code   <= '0;
        in_ch.entry_symbol <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fixed 4-bit code, symbol equals code; last entry empty
        for (int i = 0; i < 16; i++) send_entry(IDX_W'(i), LEN_W'(4), CODE_W'(i), SYM_W'(i));
        send_entry(IDX_W'(16), LEN_W'(0), 16'hFFFF, 4'hF);

        // field extremes, unused op, out-of-range index
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'hA5);
        send_beat(OP_UNUSED, 8'hFF, 5'h1F, 5'h1F, 16'hFFFF, 4'hF);
        send_entry(5'd31, LEN_W'(4), 16'h0000, 4'hF);
        send_data(8'h3C);
        send_restart();

        // code longer than the bits held
        send_entry(5'd0, LEN_W'(16), 16'hAB00, 4'd7);
        send_data(8'hAB);
        send_data(8'h3C);
        send_entry(5'd0, LEN_W'(4), 16'h0000, 4'd0);

        // miss with a pending nibble, ignored byte while stopped, then restart
        send_restart();
        send_entry(5'd0, LEN_W'(31), 16'h0000, 4'd0);
        send_data(8'h10);
        send_data(8'h00);
        send_data(8'h12);
        send_restart();
        send_entry(5'd0, LEN_W'(4), 16'h0000, 4'd0);
        send_data(8'h56);
        send_data(8'h70);

        // zero output length: finish on the first decode with no byte
        settle();
        write_length(16'd0);
        send_restart();
        send_data(8'h11);
        send_data(8'h22);

        // one output byte
        settle();
        write_length(16'd1);
        send_restart();
        send_data(8'h12);
        send_data(8'h34);

        // length lowered below the count mid-stream
        settle();
        write_length(16'hFFFF);
        send_restart();
        send_data(8'h9A);
        send_data(8'hBC);
        send_data(8'hDE);
        settle();
        write_length(16'd1);
        send_data(8'h47);

        // random phases
        run_phase(0,  0,  16'hFFFF, 40, 50, 1'b0, 1'b0);
        run_phase(65, 0,  16'd12,   16, 50, 1'b0, 1'b0);
        run_phase(0,  65, 16'hFFFF, 40, 50, 1'b1, 1'b0);
        run_phase(9,  9,  16'd3,    6,  50, 1'b0, 1'b0);
        run_phase(0,  0,  16'd300,  40, 50, 1'b0, 1'b1);
        run_phase(65, 0,  16'hFFFF, 40, 50, 1'b0, 1'b0);
        run_phase(0,  65, 16'd1,    4,  45, 1'b0, 1'b0);
        run_phase(9,  9,  16'h8000, 40, 50, 1'b0, 1'b0);

        settle();
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pcnd_pkg.sv
rtl/core/pcnd_if.sv
rtl/core/prefix_code_nibble_decoder_unit.sv
sim/pcnd_checker.sv
sim/testbench.sv
